// ===== rtl/core/dns_name_label_parser_assert.svh =====
// Assertion macros for the DNS name label parser checker.
// Used by dnp_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef DNS_NAME_LABEL_PARSER_ASSERT_SVH
`define DNS_NAME_LABEL_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dnp_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define DNP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dnp_checker: next-cycle property failed");

`endif

// ===== rtl/core/dnp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the DNS name label parser.
// No dependencies.
package dnp_pkg;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_NAME = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_CHAR = 2'd1,
        K_DONE = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE       = 3'd0,
        E_POINTER    = 3'd1,
        E_LABEL_LONG = 3'd2,
        E_TRUNCATED  = 3'd3,
        E_NO_ROOM    = 3'd4,
        E_BAD_CHAR   = 3'd5,
        E_NAME_LONG  = 3'd6
    } t_err;

    localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
    localparam logic [1:0] REG_NAME_ROOM   = 2'd1;

    localparam logic [8:0]  HEADER_SKIP_RST = 9'd12;
    localparam logic [10:0] NAME_ROOM_RST   = 11'd254;

    localparam logic [7:0] PTR_MASK  = 8'hC0;
    localparam logic [7:0] MAX_LABEL = 8'd63;
    localparam logic [8:0] BYTE_SAT  = 9'd511;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // Per-packet control state (text count lives apart, its width is parameterized)
    typedef struct packed {
        t_phase      phase;
        logic [8:0]  skip_count;
        logic [5:0]  label_left;
        logic [8:0]  byte_count;
    } t_ctl;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text_char;
        logic [8:0]  consumed_length;
        logic [7:0]  name_length;
        t_err        error_code;
    } t_result;

endpackage

// ===== rtl/core/dnp_step.sv =====
`timescale 1ns / 1ps
// Per-byte decode: next packet state and the result for one input byte.
// Depends on dnp_pkg.
module dnp_step #(
    parameter int TC_W     = 8,
    parameter int MAX_NAME = 253
) (
    input  dnp_pkg::t_ctl    i_ctl,
    input  logic [TC_W-1:0]  i_text_count,
    input  logic [8:0]       i_header_skip,
    input  logic [10:0]      i_name_room,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output dnp_pkg::t_ctl    o_ctl,
    output logic [TC_W-1:0]  o_text_count,
    output dnp_pkg::t_result o_res
);
    import dnp_pkg::*;

    localparam int NEED_W = TC_W + 2;
    localparam int CMP_W  = (NEED_W > 11) ? NEED_W : 11;

    function automatic logic char_ok(input logic [7:0] c);
        // a-z, A-Z, 0-9, '-', '_'
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F;
    endfunction

    function automatic logic [7:0] sat_len(input logic [TC_W-1:0] v);
        if ({1'b0, v} > (TC_W+1)'(255))
            return 8'hFF;
        return 8'(v);
    endfunction

    logic             w_enter;
    logic [8:0]       w_bc_inc;
    logic [TC_W-1:0]  w_tc_inc;
    logic [CMP_W-1:0] w_need;

    assign w_bc_inc = (i_ctl.byte_count < BYTE_SAT) ? i_ctl.byte_count + 9'd1
                                                     : i_ctl.byte_count;
    assign w_tc_inc = i_text_count + TC_W'(1);
    assign w_need   = CMP_W'(i_text_count) + CMP_W'(i_text_count != '0) + CMP_W'(i_data_byte);

    always_comb begin
        o_ctl        = i_ctl;
        o_text_count = i_text_count;
        o_res        = '{K_NONE, 8'd0, 9'd0, 8'd0, E_NONE};
        w_enter      = 1'b0;

        case (i_ctl.phase)
            PH_SKIP: begin
                if (i_ctl.skip_count < i_header_skip) begin
                    o_ctl.skip_count = i_ctl.skip_count + 9'd1;
                    if (i_last_byte) begin
                        if (i_name_room == 11'd0) begin
                            o_res.kind       = K_ERR;
                            o_res.error_code = E_NO_ROOM;
                        end else begin
                            o_res.kind = K_DONE;
                        end
                    end
                end else begin
                    w_enter = 1'b1;
                end
            end
            PH_NAME: w_enter = 1'b1;
            default: ;
        endcase

        if (w_enter) begin
            o_ctl.phase      = PH_NAME;
            o_ctl.byte_count = w_bc_inc;
            if (i_ctl.label_left == 6'd0) begin
                // length byte
                if (i_name_room == 11'd0) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_NO_ROOM;
                end else if ((i_data_byte & PTR_MASK) == PTR_MASK) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_POINTER;
                end else if (i_data_byte == 8'd0) begin
                    o_res.kind            = K_DONE;
                    o_res.consumed_length = w_bc_inc;
                    o_res.name_length     = sat_len(i_text_count);
                end else if (i_data_byte > MAX_LABEL) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_LABEL_LONG;
                end else if (i_last_byte) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_TRUNCATED;
                end else if (w_need >= CMP_W'(i_name_room)) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_NO_ROOM;
                end else begin
                    if (i_text_count != '0) begin
                        o_res.kind      = K_CHAR;
                        o_res.text_char = CH_DOT;
                        o_text_count    = w_tc_inc;
                    end
                    o_ctl.label_left = i_data_byte[5:0];
                end
            end else begin
                // label character
                if (i_last_byte && i_ctl.label_left > 6'd1) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_TRUNCATED;
                end else if (!char_ok(i_data_byte)) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_BAD_CHAR;
                end else if ({1'b0, i_text_count} + (TC_W+1)'(1) > (TC_W+1)'(MAX_NAME)) begin
                    o_res.kind       = K_ERR;
                    o_res.error_code = E_NAME_LONG;
                end else begin
                    o_text_count     = w_tc_inc;
                    o_ctl.label_left = i_ctl.label_left - 6'd1;
                    o_res.text_char  = i_data_byte;
                    if (i_last_byte) begin
                        o_res.kind            = K_DONE;
                        o_res.consumed_length = w_bc_inc;
                        o_res.name_length     = sat_len(w_tc_inc);
                    end else begin
                        o_res.kind = K_CHAR;
                    end
                end
            end
        end

        if (o_res.kind == K_DONE || o_res.kind == K_ERR)
            o_ctl.phase = PH_DONE;

        if (i_last_byte) begin
            o_ctl        = '{PH_SKIP, 9'd0, 6'd0, 9'd0};
            o_text_count = '0;
        end
    end

endmodule

// ===== rtl/core/dns_name_label_parser.sv =====
`timescale 1ns / 1ps
// DNS name label parser: skips a packet header and decodes length-prefixed
// labels into dotted text, one packet byte per transaction.
// Usage:
//   Input channel (i_valid / o_stall) carries one packet byte and a last flag.
//   Output channel (o_valid / i_stall) carries exactly one result per byte:
//   nothing, a text character, done (with lengths) or an error code.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   header_skip (index 0) and name_room (index 1); write only while idle.
// Output: each result is registered in the output register or, if stalled, the skid entry.
// Throughput: one byte per cycle while o_stall is low, set by the single
//   decode stage between the packet state and output registers.
// Stall: an output register plus one skid entry; while the skid entry is
//   occupied o_stall is high, so up to two results are buffered.
// Reset (synchronous, active low): header_skip = 12, name_room = 254, packet
//   state back to header skipping, output and skid empty.
// Depends on dnp_pkg and dnp_step.
module dns_name_label_parser #(
    parameter int MAX_NAME = 253
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_text_char,
    output logic [8:0]  o_consumed_length,
    output logic [7:0]  o_name_length,
    output logic [2:0]  o_error_code,
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import dnp_pkg::*;

    // text count reaches MAX_NAME + 1 at most (a dot may follow a full name)
    localparam int TC_W = $clog2(MAX_NAME + 2);

    t_ctl            r_ctl;
    logic [TC_W-1:0] r_text_count;
    logic [8:0]      r_header_skip;
    logic [10:0]     r_name_room;

    t_ctl            n_ctl;
    logic [TC_W-1:0] n_text_count;
    t_result         w_res;

    logic            r_out_valid;
    t_result         r_out;
    logic            r_skid_valid;
    t_result         r_skid;

    logic            w_in_acc;
    logic            w_out_take;

    dnp_step #(
        .TC_W     (TC_W),
        .MAX_NAME (MAX_NAME)
    ) u_step (
        .i_ctl         (r_ctl),
        .i_text_count  (r_text_count),
        .i_header_skip (r_header_skip),
        .i_name_room   (r_name_room),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_ctl         (n_ctl),
        .o_text_count  (n_text_count),
        .o_res         (w_res)
    );

    // skid entry full means the output is stalled with a result behind it
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_stall;

    // packet state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl         <= '{PH_SKIP, 9'd0, 6'd0, 9'd0};
            r_text_count  <= '0;
            r_header_skip <= HEADER_SKIP_RST;
            r_name_room   <= NAME_ROOM_RST;
        end else begin
            if (w_in_acc) begin
                r_ctl        <= n_ctl;
                r_text_count <= n_text_count;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEADER_SKIP: r_header_skip <= i_cfg_data[8:0];
                    REG_NAME_ROOM:   r_name_room   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // output register / skid valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_out_take)
                    r_skid_valid <= 1'b0;
            end else if (w_in_acc) begin
                r_out_valid <= 1'b1;
                if (r_out_valid && !w_out_take)
                    r_skid_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid && w_out_take)
            r_out <= r_skid;
        else if (w_in_acc && (!r_out_valid || w_out_take))
            r_out <= w_res;
        if (w_in_acc && r_out_valid && !w_out_take)
            r_skid <= w_res;
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_text_char       = r_out.text_char;
    assign o_consumed_length = r_out.consumed_length;
    assign o_name_length     = r_out.name_length;
    assign o_error_code      = r_out.error_code;

endmodule

// ===== rtl/core/dnp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the DNS name label parser, bound to the top level.
// Depends on dnp_pkg and dns_name_label_parser_assert.svh.
`include "dns_name_label_parser_assert.svh"
module dnp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_text_char,
    input logic [8:0]  o_consumed_length,
    input logic [7:0]  o_name_length,
    input logic [2:0]  o_error_code
);
    import dnp_pkg::*;

    `DNP_ASSERT_NOW(a_err_only_on_error, o_valid && o_kind != K_ERR, o_error_code == E_NONE)
    `DNP_ASSERT_NOW(a_err_code_set, o_valid && o_kind == K_ERR, o_error_code != E_NONE)
    `DNP_ASSERT_NOW(a_done_lengths, o_valid && o_kind == K_DONE,
                    {1'b0, o_name_length} <= o_consumed_length)
    `DNP_ASSERT_NEXT(a_stalled_hold, o_valid && i_stall,
                     o_valid && $stable(o_kind) && $stable(o_text_char))

endmodule

bind dns_name_label_parser dnp_checker u_dnp_checker (.*);
